// File: rtl/pfb_pkg.sv
// ----------------------------------------------------------------------------
// pfb_pkg: shared types and constants of the paged frame buffer
// Screen geometry, request and response payloads, the range update record and
// the controller state encoding.
// ----------------------------------------------------------------------------
package pfb_pkg;

   localparam int SCREEN_COLUMNS    = 128;
   localparam int PAGE_COUNT        = 8;
   localparam int ROWS_PER_PAGE     = 8;
   localparam int SCREEN_ROWS       = PAGE_COUNT * ROWS_PER_PAGE;
   localparam int STORE_BYTES       = SCREEN_COLUMNS * PAGE_COUNT;
   localparam int ADDR_W            = $clog2(STORE_BYTES);
   localparam int COL_W             = $clog2(SCREEN_COLUMNS);
   localparam int END_W             = $clog2(SCREEN_COLUMNS + 1);
   localparam int PAGE_W            = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
   localparam int MAX_FLUSH_RESULTS = 8;
   localparam int FLUSH_CNT_W       = $clog2(MAX_FLUSH_RESULTS);

   localparam logic [7:0] BYTE_ALL_ON  = 8'hFF;
   localparam logic [7:0] BYTE_ALL_OFF = 8'h00;

   typedef enum logic [1:0] {
      OP_SET_PIXEL = 2'd0,
      OP_FILL      = 2'd1,
      OP_READ_BYTE = 2'd2,
      OP_FLUSH     = 2'd3
   } op_type;

   typedef struct packed {
      op_type     operation;
      logic [7:0] x_coord;
      logic [7:0] y_coord;
      logic       pixel_on;
   } req_type;

   typedef struct packed {
      logic       accepted;
      logic       range_valid;
      logic [2:0] range_page;
      logic [6:0] range_begin;
      logic [7:0] range_end;
      logic [7:0] byte_data;
      logic       any_dirty;
      logic       last;
   } rsp_type;

   // One widening of a page's dirty column range
   typedef struct packed {
      logic              en;
      logic [PAGE_W-1:0] page;
      logic [COL_W-1:0]  lo;
      logic [END_W-1:0]  hi;
   } widen_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_PIXEL,
      ST_READ,
      ST_FILL,
      ST_FILL_DRAIN,
      ST_FILL_END,
      ST_FLUSH
   } state_type;

endpackage

// File: rtl/pfb_frame_ram.sv
// ----------------------------------------------------------------------------
// pfb_frame_ram: frame store memory
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module pfb_frame_ram (
   input  logic                      clock,
   input  logic                      wr_en,
   input  logic [pfb_pkg::ADDR_W-1:0] wr_addr,
   input  logic [7:0]                wr_data,
   input  logic [pfb_pkg::ADDR_W-1:0] rd_addr,
   output logic [7:0]                rd_data
);

   logic [7:0] store_ff [pfb_pkg::STORE_BYTES];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= store_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/pfb_dirty_ranges.sv
// ----------------------------------------------------------------------------
// pfb_dirty_ranges: per-page dirty column ranges
// Widens one page's range per cycle, clears all ranges at once, and presents
// the range of one selected page.
// ----------------------------------------------------------------------------
module pfb_dirty_ranges (
   input  logic                                clock,
   input  logic                                reset,
   input  pfb_pkg::widen_type                  widen,
   input  logic                                clear,
   input  logic [pfb_pkg::PAGE_W-1:0]          rd_page,
   output logic [pfb_pkg::PAGE_COUNT-1:0]      dirty,
   output logic [pfb_pkg::COL_W-1:0]           rd_first,
   output logic [pfb_pkg::END_W-1:0]           rd_last
);

   logic [pfb_pkg::PAGE_COUNT-1:0] dirty_ff, dirty_in;
   logic [pfb_pkg::COL_W-1:0]      first_ff [pfb_pkg::PAGE_COUNT];
   logic [pfb_pkg::COL_W-1:0]      first_in [pfb_pkg::PAGE_COUNT];
   logic [pfb_pkg::END_W-1:0]      last_ff  [pfb_pkg::PAGE_COUNT];
   logic [pfb_pkg::END_W-1:0]      last_in  [pfb_pkg::PAGE_COUNT];

   always_comb begin
      dirty_in = dirty_ff;
      first_in = first_ff;
      last_in  = last_ff;
      if (clear) begin
         dirty_in = '0;
      end else if (widen.en) begin
         if (!dirty_ff[widen.page]) begin
            // start a fresh range
            dirty_in[widen.page] = 1'b1;
            first_in[widen.page] = widen.lo;
            last_in[widen.page]  = widen.hi;
         end else begin
            if (widen.lo < first_ff[widen.page]) begin
               first_in[widen.page] = widen.lo;
            end
            if (widen.hi > last_ff[widen.page]) begin
               last_in[widen.page] = widen.hi;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dirty_ff <= '0;
      end else begin
         dirty_ff <= dirty_in;
      end
   end

   // Range bounds are only read while the page is dirty
   always_ff @(posedge clock) begin
      first_ff <= first_in;
      last_ff  <= last_in;
   end

   assign dirty    = dirty_ff;
   assign rd_first = first_ff[rd_page];
   assign rd_last  = last_ff[rd_page];

endmodule

// File: rtl/paged_framebuffer_dirty_tracker_top.sv
// ----------------------------------------------------------------------------
// paged_framebuffer_dirty_tracker_top: paged monochrome frame store
// Byte-per-eight-rows frame store with one dirty column range per page.
//
// Requests enter on req_data, taken at a clock edge where start is high and
// busy is low. Results leave on rsp_data, marked by rsp_valid for exactly one
// cycle; the receiver cannot stall, so results are never held back. The last
// field marks the final result of a request.
//
// Steps from the accepting edge to the result cycle:
//   set pixel, read byte : memory read, then modify and write back
//                          or return the byte
//   fill                 : one byte per cycle through the single read
//                          port, then pipeline drain
//   flush                : scans the pages in order up to the last dirty
//                          page, or gives a single result without a range
//                          when nothing is dirty. Each range leaves
//                          as its page is scanned, so clean pages between two
//                          dirty ones leave idle cycles between the results.
// The next request can be taken in the cycle the final result is shown.
//
// After reset the block runs a clearing pass over the frame store, one byte
// per cycle over all STORE_BYTES = 1024 bytes, holding busy high until it is done.
// Dirty ranges are cleared by reset at once.
// ----------------------------------------------------------------------------
module paged_framebuffer_dirty_tracker_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  pfb_pkg::req_type req_data,
   output logic             rsp_valid,
   output pfb_pkg::rsp_type rsp_data
);

   localparam int ADDR_W = pfb_pkg::ADDR_W;
   localparam int COL_W  = pfb_pkg::COL_W;
   localparam int END_W  = pfb_pkg::END_W;
   localparam int PAGE_W = pfb_pkg::PAGE_W;

   // controller state
   pfb_pkg::state_type state_ff, state_in;

   // latched request
   pfb_pkg::req_type   req_ff, req_in;
   logic               inside_ff, inside_in;
   logic [ADDR_W-1:0]  addr_ff, addr_in;

   // walk counters for clearing and fill
   logic [ADDR_W-1:0]  walk_addr_ff, walk_addr_in;
   logic [COL_W-1:0]   walk_col_ff, walk_col_in;
   logic [PAGE_W-1:0]  walk_page_ff, walk_page_in;

   // fill pipeline stage: the byte whose read data is now available
   logic               pipe_valid_ff, pipe_valid_in;
   logic [ADDR_W-1:0]  pipe_addr_ff, pipe_addr_in;
   logic [COL_W-1:0]   pipe_col_ff, pipe_col_in;
   logic [PAGE_W-1:0]  pipe_page_ff, pipe_page_in;
   logic               found_ff, found_in;
   logic [COL_W-1:0]   lo_ff, lo_in;
   logic [END_W-1:0]   hi_ff, hi_in;

   // flush scan
   logic [PAGE_W-1:0]               flush_page_ff, flush_page_in;
   logic [pfb_pkg::FLUSH_CNT_W-1:0] flush_cnt_ff, flush_cnt_in;

   // result register
   logic               rsp_valid_ff, rsp_valid_in;
   pfb_pkg::rsp_type   rsp_ff, rsp_in;

   // memory and range tracker hookup
   logic               wr_en;
   logic [ADDR_W-1:0]  wr_addr;
   logic [7:0]         wr_data;
   logic [ADDR_W-1:0]  rd_addr;
   logic [7:0]         rd_data;
   pfb_pkg::widen_type widen;
   logic               range_clear;
   logic [pfb_pkg::PAGE_COUNT-1:0] dirty_vec;
   logic [COL_W-1:0]   range_first;
   logic [END_W-1:0]   range_last;

   // request decode
   logic               req_inside;
   logic [PAGE_W-1:0]  req_page;
   logic [ADDR_W-1:0]  req_addr;

   // datapath helpers
   logic [7:0]         pix_mask;
   logic [7:0]         pix_next;
   logic               pix_changed;
   logic [7:0]         fill_byte;
   logic               pipe_changed;
   logic               page_end;
   logic [COL_W-1:0]   lo_eff;
   logic [END_W-1:0]   hi_eff;
   logic [pfb_pkg::PAGE_COUNT-1:0] later_dirty;
   logic               flush_last;

   pfb_frame_ram u_frame_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   pfb_dirty_ranges u_dirty_ranges (
      .clock    (clock),
      .reset    (reset),
      .widen    (widen),
      .clear    (range_clear),
      .rd_page  (flush_page_ff),
      .dirty    (dirty_vec),
      .rd_first (range_first),
      .rd_last  (range_last)
   );

   // Decode the request on the ports: screen bounds, page and byte address
   assign req_inside = ({1'b0, req_data.x_coord} < 9'(pfb_pkg::SCREEN_COLUMNS)) &&
                       ({1'b0, req_data.y_coord} < 9'(pfb_pkg::SCREEN_ROWS));
   assign req_page   = PAGE_W'(req_data.y_coord[7:3]);
   assign req_addr   = ADDR_W'(req_page) * ADDR_W'(pfb_pkg::SCREEN_COLUMNS) +
                       ADDR_W'(req_data.x_coord);

   // Pixel read-modify-write: set or clear one bit of the fetched byte
   assign pix_mask    = 8'(1) << req_ff.y_coord[2:0];
   assign pix_next    = req_ff.pixel_on ? (rd_data | pix_mask) : (rd_data & ~pix_mask);
   assign pix_changed = inside_ff && (pix_next != rd_data);

   // Fill: compare each fetched byte against the fill value and track the
   // changed columns of the current page
   assign fill_byte    = req_ff.pixel_on ? pfb_pkg::BYTE_ALL_ON : pfb_pkg::BYTE_ALL_OFF;
   assign pipe_changed = pipe_valid_ff && (rd_data != fill_byte);
   assign page_end     = pipe_valid_ff &&
                         (pipe_col_ff == COL_W'(pfb_pkg::SCREEN_COLUMNS - 1));
   assign lo_eff       = found_ff ? lo_ff : pipe_col_ff;
   assign hi_eff       = pipe_changed ? (END_W'(pipe_col_ff) + END_W'(1)) : hi_ff;

   // Flush: is any dirty page left beyond the one being reported
   always_comb begin
      for (int i = 0; i < pfb_pkg::PAGE_COUNT; i++) begin
         later_dirty[i] = dirty_vec[i] && (PAGE_W'(i) > flush_page_ff);
      end
   end
   assign flush_last = !(|later_dirty) ||
                       (flush_cnt_ff == pfb_pkg::FLUSH_CNT_W'(pfb_pkg::MAX_FLUSH_RESULTS - 1));

   // Fill accumulator: restart at each page end, widen with the page's span
   always_comb begin
      found_in = found_ff;
      lo_in    = lo_ff;
      hi_in    = hi_ff;
      if (state_ff == pfb_pkg::ST_IDLE) begin
         found_in = 1'b0;
      end else if (pipe_valid_ff) begin
         if (page_end) begin
            found_in = 1'b0;
         end else if (pipe_changed) begin
            found_in = 1'b1;
            lo_in    = lo_eff;
            hi_in    = hi_eff;
         end
      end
   end

   // Controller: next state, memory ports, range updates and results
   always_comb begin
      state_in      = state_ff;
      req_in        = req_ff;
      inside_in     = inside_ff;
      addr_in       = addr_ff;
      walk_addr_in  = walk_addr_ff;
      walk_col_in   = walk_col_ff;
      walk_page_in  = walk_page_ff;
      pipe_valid_in = 1'b0;
      pipe_addr_in  = walk_addr_ff;
      pipe_col_in   = walk_col_ff;
      pipe_page_in  = walk_page_ff;
      flush_page_in = flush_page_ff;
      flush_cnt_in  = flush_cnt_ff;
      rsp_valid_in  = 1'b0;
      rsp_in        = '0;
      wr_en         = 1'b0;
      wr_addr       = walk_addr_ff;
      wr_data       = pfb_pkg::BYTE_ALL_OFF;
      rd_addr       = walk_addr_ff;
      widen         = '0;
      range_clear   = 1'b0;

      case (state_ff)
         pfb_pkg::ST_CLEAR: begin
            // zero the store one byte per cycle
            wr_en        = 1'b1;
            walk_addr_in = walk_addr_ff + ADDR_W'(1);
            if (walk_addr_ff == ADDR_W'(pfb_pkg::STORE_BYTES - 1)) begin
               state_in = pfb_pkg::ST_IDLE;
            end
         end

         pfb_pkg::ST_IDLE: begin
            rd_addr = req_addr;
            if (start) begin
               req_in        = req_data;
               inside_in     = req_inside;
               addr_in       = req_addr;
               walk_addr_in  = '0;
               walk_col_in   = '0;
               walk_page_in  = '0;
               flush_page_in = '0;
               flush_cnt_in  = '0;
               case (req_data.operation)
                  pfb_pkg::OP_SET_PIXEL: state_in = pfb_pkg::ST_PIXEL;
                  pfb_pkg::OP_FILL:      state_in = pfb_pkg::ST_FILL;
                  pfb_pkg::OP_READ_BYTE: state_in = pfb_pkg::ST_READ;
                  pfb_pkg::OP_FLUSH:     state_in = pfb_pkg::ST_FLUSH;
                  default:               state_in = pfb_pkg::ST_IDLE;
               endcase
            end
         end

         pfb_pkg::ST_PIXEL: begin
            wr_en      = inside_ff;
            wr_addr    = addr_ff;
            wr_data    = pix_next;
            widen.en   = pix_changed;
            widen.page = PAGE_W'(req_ff.y_coord[7:3]);
            widen.lo   = COL_W'(req_ff.x_coord);
            widen.hi   = END_W'(req_ff.x_coord) + END_W'(1);
            rsp_valid_in       = 1'b1;
            rsp_in.accepted    = inside_ff;
            rsp_in.any_dirty   = (|dirty_vec) || pix_changed;
            rsp_in.last        = 1'b1;
            state_in           = pfb_pkg::ST_IDLE;
         end

         pfb_pkg::ST_READ: begin
            rsp_valid_in     = 1'b1;
            rsp_in.accepted  = inside_ff;
            rsp_in.byte_data = inside_ff ? rd_data : 8'h00;
            rsp_in.any_dirty = |dirty_vec;
            rsp_in.last      = 1'b1;
            state_in         = pfb_pkg::ST_IDLE;
         end

         pfb_pkg::ST_FILL, pfb_pkg::ST_FILL_DRAIN: begin
            // write back the byte fetched last cycle
            wr_en      = pipe_valid_ff;
            wr_addr    = pipe_addr_ff;
            wr_data    = fill_byte;
            widen.en   = page_end && (found_ff || pipe_changed);
            widen.page = pipe_page_ff;
            widen.lo   = lo_eff;
            widen.hi   = hi_eff;
            if (state_ff == pfb_pkg::ST_FILL) begin
               // issue the next read and advance the walk
               pipe_valid_in = 1'b1;
               walk_addr_in  = walk_addr_ff + ADDR_W'(1);
               if (walk_col_ff == COL_W'(pfb_pkg::SCREEN_COLUMNS - 1)) begin
                  walk_col_in  = '0;
                  walk_page_in = walk_page_ff + PAGE_W'(1);
               end else begin
                  walk_col_in  = walk_col_ff + COL_W'(1);
               end
               if (walk_addr_ff == ADDR_W'(pfb_pkg::STORE_BYTES - 1)) begin
                  state_in = pfb_pkg::ST_FILL_DRAIN;
               end
            end else begin
               state_in = pfb_pkg::ST_FILL_END;
            end
         end

         pfb_pkg::ST_FILL_END: begin
            rsp_valid_in     = 1'b1;
            rsp_in.accepted  = 1'b1;
            rsp_in.any_dirty = |dirty_vec;
            rsp_in.last      = 1'b1;
            state_in         = pfb_pkg::ST_IDLE;
         end

         pfb_pkg::ST_FLUSH: begin
            if (!(|dirty_vec)) begin
               // nothing dirty: one result without a range
               rsp_valid_in    = 1'b1;
               rsp_in.accepted = 1'b1;
               rsp_in.last     = 1'b1;
               state_in        = pfb_pkg::ST_IDLE;
            end else begin
               flush_page_in = flush_page_ff + PAGE_W'(1);
               if (dirty_vec[flush_page_ff]) begin
                  rsp_valid_in       = 1'b1;
                  rsp_in.accepted    = 1'b1;
                  rsp_in.range_valid = 1'b1;
                  rsp_in.range_page  = 3'(flush_page_ff);
                  rsp_in.range_begin = 7'(range_first);
                  rsp_in.range_end   = 8'(range_last);
                  rsp_in.last        = flush_last;
                  flush_cnt_in       = flush_cnt_ff + pfb_pkg::FLUSH_CNT_W'(1);
                  if (flush_last) begin
                     range_clear = 1'b1;
                     state_in    = pfb_pkg::ST_IDLE;
                  end
               end
            end
         end

         default: begin
            state_in = pfb_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= pfb_pkg::ST_CLEAR;
         walk_addr_ff  <= '0;
         pipe_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         walk_addr_ff  <= walk_addr_in;
         pipe_valid_ff <= pipe_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff        <= req_in;
      inside_ff     <= inside_in;
      addr_ff       <= addr_in;
      walk_col_ff   <= walk_col_in;
      walk_page_ff  <= walk_page_in;
      pipe_addr_ff  <= pipe_addr_in;
      pipe_col_ff   <= pipe_col_in;
      pipe_page_ff  <= pipe_page_in;
      found_ff      <= found_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      flush_page_ff <= flush_page_in;
      flush_cnt_ff  <= flush_cnt_in;
      rsp_ff        <= rsp_in;
   end

   assign busy      = (state_ff != pfb_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// File: rtl/pfb_checker.sv
// ----------------------------------------------------------------------------
// pfb_checker: port-level checks of the paged frame buffer
// Watches the request handshake and the result strobe over time.
// ----------------------------------------------------------------------------
module pfb_checker (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input logic             rsp_valid,
   input pfb_pkg::rsp_type rsp_data
);

   // no result straight out of reset
   a_no_rsp_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result strobe right after reset");

   // every accepted request makes the block go busy before its result is strobed
   a_accept_goes_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy && !rsp_valid)
      else $error("request taken without going busy");

   // only flush gives several results, and the block stays busy until the last
   a_burst_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.last |-> busy && rsp_data.range_valid)
      else $error("stray non-final result outside a flush");

   // a reported range is non-empty and carries no any_dirty flag
   a_range_sane: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.range_valid |->
         !rsp_data.any_dirty && (rsp_data.range_end > {1'b0, rsp_data.range_begin}))
      else $error("bad dirty range in flush result");

   // the final result frees the block for the next request
   a_last_frees: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.last |-> !busy)
      else $error("still busy on final result");

endmodule

bind paged_framebuffer_dirty_tracker_top pfb_checker u_pfb_checker (.*);

// File: tb/paged_framebuffer_dirty_tracker_top_tb.sv
// ----------------------------------------------------------------------------
// paged_framebuffer_dirty_tracker_top_tb: self-checking bench of the frame store
// Drives set pixel, fill, read byte and flush requests through the start/busy
// handshake. A scoreboard keeps its own copy of the frame store and the per-page
// dirty ranges, predicts every response and checks each strobed response
// against the oldest prediction. A directed opening covers the edges of the
// screen, unchanged pixels and empty flushes. Random phases with different
// amounts of sender idling follow.
// ----------------------------------------------------------------------------
module paged_framebuffer_dirty_tracker_top_tb;
   import pfb_pkg::*;

   // Timeout: clearing pass, a handful of fills and every other request
   // scanning all pages after a long idle gap, taken several times over
   localparam int LIMIT_CYCLES = 200000;
   localparam int RANDOM_FILLS = 7;
   localparam int PHASE_ITEMS  = 98;
   localparam int MAX_REPORTS  = 40;

   // -------------------------------------------------------------------------
   // Scoreboard: shadow frame store, dirty ranges and expected responses
   // -------------------------------------------------------------------------
   class frame_scoreboard;
      bit [7:0]        shadow_bytes [STORE_BYTES];
      bit              page_marked  [PAGE_COUNT];
      bit [COL_W-1:0]  col_first    [PAGE_COUNT];
      bit [END_W-1:0]  col_stop     [PAGE_COUNT];
      rsp_type         expected_rsp [$];
      int              errors;
      int              reported;

      function int outstanding();
         return expected_rsp.size();
      endfunction

      function bit any_marked();
         bit found;
         found = 1'b0;
         foreach (page_marked[p])
            found |= page_marked[p];
         return found;
      endfunction

      function void widen_page(int unsigned page, int unsigned lo, int unsigned hi);
         if (!page_marked[page]) begin
            page_marked[page] = 1'b1;
            col_first[page]   = COL_W'(lo);
            col_stop[page]    = END_W'(hi);
         end else begin
            if (lo < col_first[page])
               col_first[page] = COL_W'(lo);
            if (hi > col_stop[page])
               col_stop[page] = END_W'(hi);
         end
      endfunction

      // Advance the shadow state by one accepted request and queue its responses
      function void note_request(req_type r);
         rsp_type     want;
         bit          on_screen;
         int unsigned page, idx, lo, hi, total, n;
         bit [7:0]    prev, next, fill_byte, bit_mask;

         want        = '0;
         want.last   = 1'b1;
         on_screen   = (r.x_coord < SCREEN_COLUMNS) && (r.y_coord < SCREEN_ROWS);
         page        = r.y_coord / ROWS_PER_PAGE;
         idx         = page * SCREEN_COLUMNS + r.x_coord;
         bit_mask    = 8'h01 << r.y_coord[2:0];

         case (r.operation)
            OP_SET_PIXEL: begin
               want.accepted = on_screen;
               if (on_screen) begin
                  prev = shadow_bytes[idx];
                  next = r.pixel_on ? (prev | bit_mask) : (prev & ~bit_mask);
                  shadow_bytes[idx] = next;
                  // widen only where the byte really changed
                  if (next != prev)
                     widen_page(page, 32'(r.x_coord), 32'(r.x_coord) + 1);
               end
               want.any_dirty = any_marked();
            end
            OP_FILL: begin
               fill_byte = r.pixel_on ? BYTE_ALL_ON : BYTE_ALL_OFF;
               for (int unsigned p = 0; p < PAGE_COUNT; p++) begin
                  lo = SCREEN_COLUMNS;
                  hi = 0;
                  for (int unsigned c = 0; c < SCREEN_COLUMNS; c++) begin
                     if (shadow_bytes[p * SCREEN_COLUMNS + c] != fill_byte) begin
                        shadow_bytes[p * SCREEN_COLUMNS + c] = fill_byte;
                        if (c < lo)
                           lo = c;
                        if (c + 1 > hi)
                           hi = c + 1;
                     end
                  end
                  if (lo < hi)
                     widen_page(p, lo, hi);
               end
               want.accepted  = 1'b1;
               want.any_dirty = any_marked();
            end
            OP_READ_BYTE: begin
               want.accepted = on_screen;
               if (on_screen)
                  want.byte_data = shadow_bytes[idx];
               want.any_dirty = any_marked();
            end
            OP_FLUSH: begin
               total = 0;
               foreach (page_marked[p])
                  total += page_marked[p];
               want.accepted = 1'b1;
               if (total == 0) begin
                  expected_rsp.push_back(want);
               end else begin
                  n = 0;
                  for (int unsigned p = 0; p < PAGE_COUNT; p++) begin
                     if (page_marked[p]) begin
                        want.range_valid = 1'b1;
                        want.range_page  = 3'(p);
                        want.range_begin = col_first[p];
                        want.range_end   = col_stop[p];
                        want.last        = (n + 1 == total);
                        expected_rsp.push_back(want);
                        n++;
                     end
                  end
               end
               foreach (page_marked[p]) begin
                  page_marked[p] = 1'b0;
                  col_first[p]   = '0;
                  col_stop[p]    = '0;
               end
            end
         endcase
         if (r.operation != OP_FLUSH)
            expected_rsp.push_back(want);
      endfunction

      function void compare_field(string name, logic [7:0] want, logic [7:0] got);
         if (want !== got) begin
            errors++;
            if (reported < MAX_REPORTS)
               $display("%0t: mismatch on %s: expected %0h, actual %0h",
                        $time, name, want, got);
            reported++;
         end
      endfunction

      // Check one strobed response against the oldest prediction
      function void check_response(rsp_type got);
         rsp_type want;
         if (expected_rsp.size() == 0) begin
            errors++;
            $display("%0t: unexpected response: expected none, actual %h", $time, got);
            return;
         end
         want = expected_rsp.pop_front();
         compare_field("accepted",    8'(want.accepted),    8'(got.accepted));
         compare_field("range_valid", 8'(want.range_valid), 8'(got.range_valid));
         compare_field("range_page",  8'(want.range_page),  8'(got.range_page));
         compare_field("range_begin", 8'(want.range_begin), 8'(got.range_begin));
         compare_field("range_end",   want.range_end,       got.range_end);
         compare_field("byte_data",   want.byte_data,       got.byte_data);
         compare_field("any_dirty",   8'(want.any_dirty),   8'(got.any_dirty));
         compare_field("last",        8'(want.last),        8'(got.last));
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // Signals and block instance
   // -------------------------------------------------------------------------
   logic    clock    = 1'b0;
   logic    reset    = 1'b1;
   logic    start    = 1'b0;
   req_type req_data = '0;
   logic    busy;
   logic    rsp_valid;
   rsp_type rsp_data;

   frame_scoreboard sb = new;

   int       fills_left = RANDOM_FILLS;
   bit [7:0] last_x     = '0;
   bit [7:0] last_y     = '0;

   paged_framebuffer_dirty_tracker_top uut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // -------------------------------------------------------------------------
   // Monitor: sample both channels at the rising edge. Check the response
   // first, so a request taken in the cycle of a final response queues behind.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid === 1'b1)
            sb.check_response(rsp_data);
         if (start === 1'b1 && busy === 1'b0)
            sb.note_request(req_data);
      end
   end

   // -------------------------------------------------------------------------
   // Stimulus helpers
   // -------------------------------------------------------------------------
   function req_type make_request(op_type op, bit [7:0] x, bit [7:0] y, bit on);
      req_type r;
      r.operation = op;
      r.x_coord   = x;
      r.y_coord   = y;
      r.pixel_on  = on;
      return r;
   endfunction

   // Idle the sender at random, then hold the request until busy drops.
   // Start stays high when back-to-back, so it is never lowered and raised
   // in the same step.
   task send_request(input req_type r, input int idle_pct);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= r;
      do
         @(posedge clock);
      while (busy !== 1'b0);
   endtask

   // Hold the sender off until every predicted response has come back
   task wait_drained();
      start <= 1'b0;
      @(posedge clock);
      while (sb.outstanding() != 0)
         @(posedge clock);
   endtask

   // Mostly well-formed requests on the screen, some clustered so that pixels
   // repeat, reads that revisit the last pixel, and a share of wild coordinates
   function req_type random_request();
      req_type     r;
      int unsigned pick;
      op_type      op;
      pick = $urandom_range(99);
      if (pick < 3 && fills_left > 0) begin
         op = OP_FILL;
         fills_left--;
      end else if (pick < 60) begin
         op = OP_SET_PIXEL;
      end else if (pick < 85) begin
         op = OP_READ_BYTE;
      end else begin
         op = OP_FLUSH;
      end
      r = make_request(op, 8'($urandom_range(127)), 8'($urandom_range(SCREEN_ROWS - 1)),
                       1'($urandom_range(1)));
      pick = $urandom_range(99);
      if (pick < 15) begin
         r.x_coord = 8'($urandom_range(255));
         r.y_coord = 8'($urandom_range(255));
      end else if (pick < 45 && op == OP_READ_BYTE) begin
         r.x_coord = last_x;
         r.y_coord = last_y;
      end else if (pick < 45) begin
         r.x_coord = 8'($urandom_range(7));
         r.y_coord = 8'($urandom_range(15));
      end
      if (op == OP_SET_PIXEL) begin
         last_x = r.x_coord;
         last_y = r.y_coord;
      end
      return r;
   endfunction

   // -------------------------------------------------------------------------
   // Main sequence
   // -------------------------------------------------------------------------
   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed: the clearing pass holds the first request off through busy
      send_request(make_request(OP_READ_BYTE, 8'd0,   8'd0,   1'b1), 0);
      // empty flush gives one invalid range
      send_request(make_request(OP_FLUSH,     8'd0,   8'd0,   1'b0), 0);
      send_request(make_request(OP_SET_PIXEL, 8'd0,   8'd0,   1'b1), 0);
      // same pixel again leaves the ranges alone
      send_request(make_request(OP_SET_PIXEL, 8'd0,   8'd0,   1'b1), 0);
      send_request(make_request(OP_SET_PIXEL, 8'd127, 8'd63,  1'b1), 0);
      // just outside the screen on each axis, and far outside
      send_request(make_request(OP_SET_PIXEL, 8'd128, 8'd0,   1'b1), 0);
      send_request(make_request(OP_SET_PIXEL, 8'd0,   8'd64,  1'b1), 0);
      send_request(make_request(OP_SET_PIXEL, 8'd255, 8'd255, 1'b1), 0);
      send_request(make_request(OP_READ_BYTE, 8'd0,   8'd0,   1'b0), 0);
      send_request(make_request(OP_READ_BYTE, 8'd127, 8'd63,  1'b0), 0);
      send_request(make_request(OP_READ_BYTE, 8'd128, 8'd5,   1'b1), 0);
      send_request(make_request(OP_READ_BYTE, 8'd3,   8'd255, 1'b0), 0);
      // darkening a dark pixel changes nothing
      send_request(make_request(OP_SET_PIXEL, 8'd5,   8'd7,   1'b0), 0);
      send_request(make_request(OP_FLUSH,     8'd200, 8'd100, 1'b1), 0);
      send_request(make_request(OP_FLUSH,     8'd0,   8'd0,   1'b0), 0);
      // fill lit marks every page, then a single dark pixel marks one column
      send_request(make_request(OP_FILL,      8'd0,   8'd0,   1'b1), 0);
      send_request(make_request(OP_SET_PIXEL, 8'd64,  8'd33,  1'b1), 0);
      send_request(make_request(OP_SET_PIXEL, 8'd64,  8'd33,  1'b0), 0);
      send_request(make_request(OP_FLUSH,     8'd0,   8'd0,   1'b0), 0);
      send_request(make_request(OP_FILL,      8'd0,   8'd0,   1'b1), 0);
      send_request(make_request(OP_FLUSH,     8'd0,   8'd0,   1'b1), 0);
      send_request(make_request(OP_FILL,      8'd0,   8'd0,   1'b0), 0);
      send_request(make_request(OP_FILL,      8'd0,   8'd0,   1'b0), 0);
      send_request(make_request(OP_FLUSH,     8'd0,   8'd0,   1'b0), 0);
      send_request(make_request(OP_READ_BYTE, 8'd10,  8'd10,  1'b1), 0);

      // Pause until the directed responses are all back
      wait_drained();

      // Random: back to back, then a sparse sender, then a lightly idling one
      for (int i = 0; i < PHASE_ITEMS; i++)
         send_request(random_request(), 0);
      wait_drained();
      for (int i = 0; i < PHASE_ITEMS; i++)
         send_request(random_request(), 85);
      wait_drained();
      for (int i = 0; i < PHASE_ITEMS; i++)
         send_request(random_request(), 8);

      // Drain, then keep watching for stray strobes
      wait_drained();
      repeat (16) @(posedge clock);

      if (sb.errors == 0 && sb.outstanding() == 0) begin
         $display("TEST PASSED");
      end else begin
         if (sb.outstanding() != 0)
            $display("%0t: %0d responses never arrived", $time, sb.outstanding());
         $display("TEST FAILED");
      end
      $finish;
   end

   // Timeout
   initial begin
      #(LIMIT_CYCLES * 10);
      $display("TEST FAILED");
      $finish;
   end

endmodule

// File: sim.f
rtl/pfb_pkg.sv
rtl/pfb_frame_ram.sv
rtl/pfb_dirty_ranges.sv
rtl/paged_framebuffer_dirty_tracker_top.sv
rtl/pfb_checker.sv
tb/paged_framebuffer_dirty_tracker_top_tb.sv
